// File: hdl/tpa_pkg.sv
// Shared constants, record and configuration types, and slot arithmetic for the pair aligner.
`default_nettype none

package tpa_pkg;

    localparam int NUM_SOURCES = 4;
    localparam int DEPTH       = 16;

    localparam int SRC_IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int HEAD_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W   = $clog2(DEPTH + 1);
    localparam int ADDR_W    = $clog2(NUM_SOURCES * DEPTH);

    localparam int SRC_W      = 2;
    localparam int HANDLE_W   = 16;
    localparam int TIME_W     = 63;
    localparam int SEQ_W      = 32;
    localparam int DIFF_W     = 64;
    localparam int DROP_W     = 16;
    localparam int QDEPTH_W   = 5;
    localparam int THR_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 192;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_DEPTH     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THRESHOLD = 1'b1;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    localparam logic [QDEPTH_W-1:0] QUEUE_DEPTH_RESET     = 5'd4;
    localparam logic [THR_W-1:0]    MATCH_THRESHOLD_RESET = 32'd1000000;

    typedef struct packed {
        logic [TIME_W-1:0]   capture_time;
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] handle;
    } record_t;

    localparam int RECORD_W = $bits(record_t);

    typedef struct packed {
        logic [QDEPTH_W-1:0] queue_depth;
        logic [THR_W-1:0]    match_threshold;
    } cfg_t;

    // Reduces a slot sum below twice the queue size back into the ring.
    function automatic logic [HEAD_W-1:0] wrap_slot(input logic [COUNT_W:0] sum);
        logic [COUNT_W:0] r;
        if (sum >= (COUNT_W + 1)'(DEPTH))
        begin
            r = sum - (COUNT_W + 1)'(DEPTH);
        end
        else
        begin
            r = sum;
        end
        return r[HEAD_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SRC_IDX_W-1:0] src,
                                                    input logic [HEAD_W-1:0] slot);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(src) * ADDR_W'(DEPTH);
        return base + ADDR_W'(slot);
    endfunction

endpackage

`default_nettype wire

// File: hdl/timestamp_pair_aligner_top.sv
// Top level of the timestamp pair aligner: configuration registers, record memory and control.
//
// The block keeps a bounded queue of frame records (handle, capture time, sequence number)
// for each source in one record memory and pairs queue heads whose capture times lie within
// the match threshold. A push transfer (tuser 0) produces no result and leaves the block
// ready for the next transfer. A take transfer (tuser 1) produces exactly one result and
// occupies the block while it compares head pairs (at most 2*DEPTH - 1 pairs); each
// comparison passes through a scan state and a compare state, as the record memory returns
// registered read data. A finished result waits in the output register, and the block
// accepts the next transfer while it waits; a following take holds in its finish state
// until that register is free. The record memory needs no clearing after reset.
`default_nettype none

module timestamp_pair_aligner_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // s_tdata: source, second_source, frame_handle, frame_empty, capture_time, zero pad
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [tpa_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: op
    input  wire logic [0:0]                       s_tuser,
    // m_tdata: first_handle, second_handle, first_seq, second_seq, time_difference,
    //          first source drop count, second source drop count
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [tpa_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: matched
    output logic      [0:0]                       m_tuser,
    input  wire logic                             cfg_we,
    input  wire logic [tpa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tpa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import tpa_pkg::*;

    logic [QDEPTH_W-1:0] queue_depth_reg;
    logic [THR_W-1:0]    match_threshold_reg;
    cfg_t                cfg;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    record_t             ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr_a;
    logic [ADDR_W-1:0]   ram_raddr_b;
    logic [RECORD_W-1:0] ram_rdata_a;
    logic [RECORD_W-1:0] ram_rdata_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_depth_reg     <= QUEUE_DEPTH_RESET;
            match_threshold_reg <= MATCH_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_QUEUE_DEPTH:
                begin
                    queue_depth_reg <= cfg_wdata[QDEPTH_W-1:0];
                end
                CFG_MATCH_THRESHOLD:
                begin
                    match_threshold_reg <= cfg_wdata[THR_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = '{queue_depth: queue_depth_reg, match_threshold: match_threshold_reg};

    tpa_ram #(
        .DATA_W (RECORD_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    tpa_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_a (ram_rdata_a),
        .ram_rdata_b (ram_rdata_b)
    );

endmodule

`default_nettype wire

// File: hdl/tpa_ram.sv
// Simple dual-read, single-write synchronous RAM with registered read data.
`default_nettype none

module tpa_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [DATA_W-1:0] rdata_a,
    output logic      [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

`default_nettype wire

// File: hdl/tpa_ctrl.sv
// Queue bookkeeping, push update, take sequencer and output register of the pair aligner.
`default_nettype none

module tpa_ctrl (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire tpa_pkg::cfg_t                    cfg,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [tpa_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [0:0]                       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [tpa_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic      [0:0]                       m_tuser,
    output logic                                  ram_we,
    output logic      [tpa_pkg::ADDR_W-1:0]       ram_waddr,
    output tpa_pkg::record_t                      ram_wdata,
    output logic      [tpa_pkg::ADDR_W-1:0]       ram_raddr_a,
    output logic      [tpa_pkg::ADDR_W-1:0]       ram_raddr_b,
    input  wire logic [tpa_pkg::RECORD_W-1:0]     ram_rdata_a,
    input  wire logic [tpa_pkg::RECORD_W-1:0]     ram_rdata_b
);

    import tpa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMPARE,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [HEAD_W-1:0]  head_reg  [NUM_SOURCES];
    logic [HEAD_W-1:0]  head_next [NUM_SOURCES];
    logic [COUNT_W-1:0] count_reg  [NUM_SOURCES];
    logic [COUNT_W-1:0] count_next [NUM_SOURCES];
    logic [SEQ_W-1:0]   seq_reg  [NUM_SOURCES];
    logic [SEQ_W-1:0]   seq_next [NUM_SOURCES];
    logic [DROP_W-1:0]  ovf_reg  [NUM_SOURCES];
    logic [DROP_W-1:0]  ovf_next [NUM_SOURCES];

    logic [SRC_IDX_W-1:0] a_reg, a_next;
    logic [SRC_IDX_W-1:0] b_reg, b_next;
    logic                 va_reg, va_next;
    logic                 vb_reg, vb_next;
    logic [DROP_W-1:0]    da_reg, da_next;
    logic [DROP_W-1:0]    db_reg, db_next;
    logic                 hit_reg, hit_next;
    record_t              hit_a_reg, hit_a_next;
    record_t              hit_b_reg, hit_b_next;
    logic [DIFF_W-1:0]    diff_reg, diff_next;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 m_user_reg, m_user_next;

    logic                 in_op;
    logic [SRC_W-1:0]     in_src;
    logic [SRC_W-1:0]     in_src2;
    logic [HANDLE_W-1:0]  in_handle;
    logic                 in_empty;
    logic [TIME_W-1:0]    in_time;
    logic                 src_ok;
    logic                 src2_ok;
    logic [SRC_IDX_W-1:0] p_idx;
    logic [SRC_IDX_W-1:0] p_idx2;

    logic [COUNT_W-1:0]   d_eff;
    logic [COUNT_W-1:0]   p_cnt;
    logic [COUNT_W-1:0]   p_pops;
    logic                 p_extra;
    logic [HEAD_W-1:0]    p_head_new;
    logic [COUNT_W-1:0]   p_cnt_kept;
    logic [HEAD_W-1:0]    p_slot;
    logic [DROP_W:0]      p_ovf_sum;
    logic [DROP_W-1:0]    p_ovf_sat;
    logic [SEQ_W-1:0]     p_seq;

    record_t              rec_a;
    record_t              rec_b;
    logic [TIME_W-1:0]    mag;
    logic                 is_match;
    logic [COUNT_W-1:0]   cnt_a;
    logic [COUNT_W-1:0]   cnt_b;

    assign in_op     = s_tuser[0];
    assign in_src    = s_tdata[1:0];
    assign in_src2   = s_tdata[3:2];
    assign in_handle = s_tdata[19:4];
    assign in_empty  = s_tdata[20];
    assign in_time   = s_tdata[83:21];

    assign src_ok  = 32'(in_src) < 32'(NUM_SOURCES);
    assign src2_ok = 32'(in_src2) < 32'(NUM_SOURCES);
    assign p_idx   = SRC_IDX_W'(in_src);
    assign p_idx2  = SRC_IDX_W'(in_src2);

    // Overflow trimming of a push is done in closed form: every record beyond depth minus one
    // leaves the head at once, and a zero depth also drops the new record.
    assign d_eff = (32'(cfg.queue_depth) > 32'(DEPTH)) ? COUNT_W'(DEPTH)
                                                       : COUNT_W'(cfg.queue_depth);
    assign p_cnt = count_reg[p_idx];

    always_comb
    begin
        if (d_eff == '0)
        begin
            p_pops  = p_cnt;
            p_extra = 1'b1;
        end
        else if (p_cnt >= d_eff)
        begin
            p_pops  = p_cnt + COUNT_W'(1) - d_eff;
            p_extra = 1'b0;
        end
        else
        begin
            p_pops  = '0;
            p_extra = 1'b0;
        end
    end

    assign p_head_new = wrap_slot((COUNT_W + 1)'(head_reg[p_idx]) + (COUNT_W + 1)'(p_pops));
    assign p_cnt_kept = p_cnt - p_pops;
    assign p_slot     = wrap_slot((COUNT_W + 1)'(p_head_new) + (COUNT_W + 1)'(p_cnt_kept));
    assign p_ovf_sum  = (DROP_W + 1)'(ovf_reg[p_idx]) + (DROP_W + 1)'(p_pops)
                      + (DROP_W + 1)'(p_extra);
    assign p_ovf_sat  = p_ovf_sum[DROP_W] ? '1 : p_ovf_sum[DROP_W-1:0];
    assign p_seq      = seq_reg[p_idx] + SEQ_W'(1);

    assign rec_a    = ram_rdata_a;
    assign rec_b    = ram_rdata_b;
    assign mag      = (rec_a.capture_time >= rec_b.capture_time)
                    ? rec_a.capture_time - rec_b.capture_time
                    : rec_b.capture_time - rec_a.capture_time;
    assign is_match = (mag[TIME_W-1:THR_W] == '0) && (mag[THR_W-1:0] <= cfg.match_threshold);
    assign cnt_a    = count_reg[a_reg];
    assign cnt_b    = count_reg[b_reg];

    assign ram_raddr_a = slot_addr(a_reg, head_reg[a_reg]);
    assign ram_raddr_b = slot_addr(b_reg, head_reg[b_reg]);
    assign ram_waddr   = slot_addr(p_idx, p_slot);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        seq_next     = seq_reg;
        ovf_next     = ovf_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        va_next      = va_reg;
        vb_next      = vb_reg;
        da_next      = da_reg;
        db_next      = db_reg;
        hit_next     = hit_reg;
        hit_a_next   = hit_a_reg;
        hit_b_next   = hit_b_reg;
        diff_next    = diff_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        ram_we       = 1'b0;
        ram_wdata    = '{capture_time: in_time, seq: p_seq, handle: in_handle};

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_op == OP_PUSH)
                    begin
                        if (src_ok && !in_empty)
                        begin
                            seq_next[p_idx]   = p_seq;
                            head_next[p_idx]  = p_head_new;
                            count_next[p_idx] = (d_eff == '0) ? '0
                                              : p_cnt_kept + COUNT_W'(1);
                            ovf_next[p_idx]   = p_ovf_sat;
                            ram_we            = (d_eff != '0);
                        end
                    end
                    else
                    begin
                        a_next   = p_idx;
                        b_next   = p_idx2;
                        va_next  = src_ok;
                        vb_next  = src2_ok;
                        da_next  = src_ok ? ovf_reg[p_idx] : '0;
                        db_next  = src2_ok ? ovf_reg[p_idx2] : '0;
                        hit_next = 1'b0;
                        if (src_ok)
                        begin
                            ovf_next[p_idx] = '0;
                        end
                        if (src2_ok)
                        begin
                            ovf_next[p_idx2] = '0;
                        end
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (va_reg && vb_reg && (cnt_a != '0) && (cnt_b != '0))
                begin
                    state_next = ST_COMPARE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_COMPARE:
            begin
                if (is_match)
                begin
                    hit_next   = 1'b1;
                    hit_a_next = rec_a;
                    hit_b_next = rec_b;
                    diff_next  = {1'b0, rec_a.capture_time} - {1'b0, rec_b.capture_time};
                    head_next[a_reg]  = wrap_slot((COUNT_W + 1)'(head_reg[a_reg])
                                                  + (COUNT_W + 1)'(1));
                    count_next[a_reg] = cnt_a - COUNT_W'(1);
                    if (b_reg != a_reg)
                    begin
                        head_next[b_reg]  = wrap_slot((COUNT_W + 1)'(head_reg[b_reg])
                                                      + (COUNT_W + 1)'(1));
                        count_next[b_reg] = cnt_b - COUNT_W'(1);
                    end
                    state_next = ST_FINISH;
                end
                else if (rec_a.capture_time < rec_b.capture_time)
                begin
                    head_next[a_reg]  = wrap_slot((COUNT_W + 1)'(head_reg[a_reg])
                                                  + (COUNT_W + 1)'(1));
                    count_next[a_reg] = cnt_a - COUNT_W'(1);
                    da_next           = (da_reg == '1) ? da_reg : da_reg + DROP_W'(1);
                    state_next        = ST_SCAN;
                end
                else
                begin
                    head_next[b_reg]  = wrap_slot((COUNT_W + 1)'(head_reg[b_reg])
                                                  + (COUNT_W + 1)'(1));
                    count_next[b_reg] = cnt_b - COUNT_W'(1);
                    db_next           = (db_reg == '1) ? db_reg : db_reg + DROP_W'(1);
                    state_next        = ST_SCAN;
                end
            end

            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = hit_reg;
                    if (hit_reg)
                    begin
                        m_data_next = {db_reg, da_reg, diff_reg, hit_b_reg.seq, hit_a_reg.seq,
                                       hit_b_reg.handle, hit_a_reg.handle};
                    end
                    else
                    begin
                        m_data_next = {db_reg, da_reg, (M_TDATA_W - 2 * DROP_W)'(0)};
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            hit_reg     <= 1'b0;
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
                seq_reg[i]   <= '0;
                ovf_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            va_reg      <= va_next;
            vb_reg      <= vb_next;
            hit_reg     <= hit_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            seq_reg     <= seq_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        da_reg     <= da_next;
        db_reg     <= db_next;
        hit_a_reg  <= hit_a_next;
        hit_b_reg  <= hit_b_next;
        diff_reg   <= diff_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// File: hdl/tpa_checker.sv
// Port-level assertions for the timestamp pair aligner and their bind to the top level.
`default_nettype none

module tpa_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [0:0]                     s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [tpa_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic [0:0]                     m_tuser
);

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    // A result without a match carries zero handles, sequence numbers and difference.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[159:0] == '0))
        else $error("unmatched result carries pair fields");

    // A push never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser[0] && !m_tvalid) |=> !m_tvalid)
        else $error("push produced a result");

    // A take occupies the block for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser[0]) |=> !s_tready)
        else $error("transfer accepted while a take is in progress");

endmodule

bind timestamp_pair_aligner_top tpa_checker u_tpa_checker (.*);

`default_nettype wire
